/* sv/task_state_scheduler_core_assert.svh */
// Assertion macros for the task scheduler checker
`ifndef TASK_STATE_SCHEDULER_CORE_ASSERT_SVH
`define TASK_STATE_SCHEDULER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define TSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Types, constants and codes shared by the task scheduler files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;
  localparam int MaxTasks   = 16;
  localparam int EventBytes = 4;
  localparam int EvW        = 8 * EventBytes;
  localparam int TidW       = 4;
  localparam int CntW       = 5;

  typedef enum logic [3:0] {
    FN_CREATE   = 4'd0,
    FN_WAIT_TIME = 4'd1,
    FN_WAIT_EVENT = 4'd2,
    FN_WAIT_SEM = 4'd3,
    FN_SIGNAL   = 4'd4,
    FN_RELEASE  = 4'd5,
    FN_TICK     = 4'd6,
    FN_SUSPEND  = 4'd7,
    FN_RESUME   = 4'd8,
    FN_KILL     = 4'd9,
    FN_PICK     = 4'd10
  } func_t;

  typedef enum logic [2:0] {
    ST_SUSPENDED = 3'd0,
    ST_READY     = 3'd1,
    ST_WAIT_TIME = 3'd2,
    ST_WAIT_EVENT = 3'd3,
    ST_WAIT_EVENT_TO = 3'd4,
    ST_WAIT_SEM  = 3'd5,
    ST_KILLED    = 3'd6
  } run_t;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_BAD  = 2'd1;
  localparam logic [1:0] STS_DUP  = 2'd2;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  task_id;
    logic [7:0]  priority_req;
    logic [4:0]  event_id;
    logic        single_event;
    logic [31:0] time_amount;
    logic [7:0]  clock_sel;
    logic [7:0]  sem_id;
  } req_t;

  typedef struct packed {
    logic [3:0] chosen_task;
    logic       task_found;
    logic [1:0] status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request, clear scan state
    logic step;     // process record idx
    logic finish;   // apply result, build response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;     // scan index at end
  } sts_t;
endpackage
`default_nettype wire

/* sv/tss_if.sv */
// ----------------------------------------------------------------------------
// tss_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tss_req_if;
  import tss_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tss_rsp_if;
  import tss_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: accept a beat, scan the table, hand the result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tss_pkg::cmd_t      cmd,
  input  wire tss_pkg::sts_t sts
);
  import tss_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;
  state_t state, state_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    out_valid_next = out_valid;
    cmd = '0;
    in_ready = 1'b0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

/* sv/tss_dp.sv */
// ----------------------------------------------------------------------------
// tss_dp
// Task table and per-record scan logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tss_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rr_mode,
  input  wire tss_pkg::req_t req,
  input  wire tss_pkg::cmd_t cmd,
  output tss_pkg::sts_t      sts,
  output tss_pkg::rsp_t      rsp
);
  import tss_pkg::*;

  run_t        run_state [MaxTasks];
  run_t        saved_state [MaxTasks];
  logic [7:0]  prio [MaxTasks];
  logic [31:0] timer [MaxTasks];
  logic [7:0]  tclk [MaxTasks];
  logic [7:0]  asem [MaxTasks];
  logic [EvW-1:0] evmap [MaxTasks];
  logic        one [MaxTasks];
  logic [CntW-1:0] created;
  logic [TidW-1:0] last_picked;
  logic        last_valid;

  req_t        r;
  logic [CntW-1:0] idx;      // scan position 0..MaxTasks
  logic [TidW-1:0] rr_pos;   // round robin probe position
  logic        have, any, dup;
  logic [TidW-1:0] best, last_w;
  logic [7:0]  best_prio;
  logic [31:0] longest;
  rsp_t        rsp_next;

  logic [TidW-1:0] i;
  logic        in_tbl;
  logic [EvW-1:0] evbit;
  logic [CntW-1:0] n;
  logic        tid_ok;

  assign n = created;
  assign i = idx[TidW-1:0];
  assign in_tbl = idx < n;
  assign tid_ok = {1'b0, r.task_id} < n;
  assign evbit = ({{(EvW-1){1'b0}}, 1'b1} << r.event_id[4:0]);
  assign sts.last = (idx >= CntW'(MaxTasks - 1));

  function automatic logic [TidW-1:0] wrap_inc(logic [TidW-1:0] x, logic [CntW-1:0] lim);
    logic [CntW-1:0] y;
    y = {1'b0, x} + CntW'(1);
    return (y >= lim) ? '0 : y[TidW-1:0];
  endfunction

  // response for the request in work, registered on finish
  always_comb begin
    rsp_next = '0;
    case (r.func)
      FN_CREATE: begin
        if (n >= CntW'(MaxTasks)) rsp_next.status = STS_BAD;
        else if (dup) rsp_next.status = STS_DUP;
        else begin
          rsp_next.chosen_task = n[TidW-1:0];
          rsp_next.task_found = 1'b1;
        end
      end
      FN_WAIT_TIME, FN_WAIT_EVENT, FN_WAIT_SEM, FN_SUSPEND, FN_RESUME, FN_KILL: begin
        if (!tid_ok) rsp_next.status = STS_BAD;
      end
      FN_PICK: begin
        rsp_next.chosen_task = have ? best : '0;
        rsp_next.task_found = have;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MaxTasks; k++) begin
        run_state[k] <= ST_SUSPENDED;
        saved_state[k] <= ST_SUSPENDED;
        prio[k] <= '0;
        timer[k] <= '0;
        tclk[k] <= 8'hFF;
        asem[k] <= '0;
        evmap[k] <= '0;
        one[k] <= 1'b0;
      end
      created <= '0;
      last_picked <= '0;
      last_valid <= 1'b1;
      idx <= '0;
      rr_pos <= '0;
      have <= 1'b0;
      any <= 1'b0;
      dup <= 1'b0;
      best <= '0;
      last_w <= '0;
      best_prio <= '0;
      longest <= '0;
      rsp <= '0;
    end else if (cmd.load) begin
      r <= req;
      idx <= '0;
      have <= 1'b0;
      any <= 1'b0;
      dup <= 1'b0;
      best <= '0;
      last_w <= '0;
      best_prio <= '0;
      longest <= '0;
      rr_pos <= last_valid ? wrap_inc(last_picked, n) : '0;
    end else if (cmd.step) begin
      idx <= idx + CntW'(1);
      case (r.func)
        FN_CREATE: if (in_tbl && prio[i] == r.priority_req) dup <= 1'b1;
        FN_SIGNAL: begin
          if (in_tbl && (run_state[i] == ST_WAIT_EVENT ||
              run_state[i] == ST_WAIT_EVENT_TO) && (evmap[i] & evbit) != '0) begin
            if (one[i] || (evmap[i] & ~evbit) == '0) begin
              evmap[i] <= '0;
              one[i] <= 1'b0;
              run_state[i] <= ST_READY;
            end else evmap[i] <= evmap[i] & ~evbit;
          end
        end
        FN_RELEASE: begin
          if (in_tbl && run_state[i] == ST_WAIT_SEM && asem[i] == r.sem_id) begin
            if (rr_mode) begin
              any <= 1'b1;
              last_w <= i;
              if (timer[i] > longest) begin
                longest <= timer[i];
                best <= i;
                have <= 1'b1;
              end
            end else if (!have || prio[i] < best_prio) begin
              best_prio <= prio[i];
              best <= i;
              have <= 1'b1;
            end
          end
        end
        FN_TICK: begin
          if (in_tbl) begin
            if (run_state[i] == ST_WAIT_TIME || run_state[i] == ST_WAIT_EVENT_TO) begin
              if (tclk[i] == r.clock_sel) begin
                if (timer[i] <= r.time_amount) begin
                  timer[i] <= '0;
                  if (run_state[i] == ST_WAIT_EVENT_TO) begin
                    evmap[i] <= '0;
                    one[i] <= 1'b0;
                  end
                  run_state[i] <= ST_READY;
                end else timer[i] <= timer[i] - r.time_amount;
              end
            end else if (run_state[i] == ST_WAIT_SEM && timer[i] != 32'hFFFF_FFFF)
              timer[i] <= timer[i] + 32'd1;
          end
        end
        FN_PICK: begin
          if (rr_mode) begin
            if (in_tbl && !have) begin
              if (run_state[rr_pos] == ST_READY) begin
                have <= 1'b1;
                best <= rr_pos;
              end else rr_pos <= wrap_inc(rr_pos, n);
            end
          end else if (in_tbl && run_state[i] == ST_READY &&
                       (!have || prio[i] < best_prio)) begin
            best_prio <= prio[i];
            best <= i;
            have <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.finish) begin
      rsp <= rsp_next;
      case (r.func)
        FN_CREATE: begin
          if (n < CntW'(MaxTasks) && !dup) begin
            prio[n[TidW-1:0]] <= r.priority_req;
            run_state[n[TidW-1:0]] <= ST_READY;
            saved_state[n[TidW-1:0]] <= ST_READY;
            asem[n[TidW-1:0]] <= '0;
            timer[n[TidW-1:0]] <= '0;
            evmap[n[TidW-1:0]] <= '0;
            one[n[TidW-1:0]] <= 1'b0;
            created <= n + CntW'(1);
          end
        end
        FN_WAIT_TIME: begin
          if (tid_ok) begin
            tclk[r.task_id] <= r.clock_sel;
            timer[r.task_id] <= r.time_amount;
            run_state[r.task_id] <= ST_WAIT_TIME;
          end
        end
        FN_WAIT_EVENT: begin
          if (tid_ok) begin
            evmap[r.task_id] <= evmap[r.task_id] | evbit;
            one[r.task_id] <= r.single_event;
            if (r.time_amount != '0) begin
              tclk[r.task_id] <= '0;
              timer[r.task_id] <= r.time_amount;
              run_state[r.task_id] <= ST_WAIT_EVENT_TO;
            end else run_state[r.task_id] <= ST_WAIT_EVENT;
          end
        end
        FN_WAIT_SEM: begin
          if (tid_ok) begin
            timer[r.task_id] <= '0;
            run_state[r.task_id] <= ST_WAIT_SEM;
            asem[r.task_id] <= r.sem_id;
          end
        end
        FN_RELEASE: begin
          if (rr_mode && longest == '0 && any) run_state[last_w] <= ST_READY;
          else if (have) run_state[best] <= ST_READY;
        end
        FN_SUSPEND: begin
          if (tid_ok && run_state[r.task_id] != ST_KILLED &&
              run_state[r.task_id] != ST_SUSPENDED) begin
            saved_state[r.task_id] <= (run_state[r.task_id] == ST_WAIT_SEM) ?
                                      ST_READY : run_state[r.task_id];
            run_state[r.task_id] <= ST_SUSPENDED;
          end
        end
        FN_RESUME: begin
          if (tid_ok && run_state[r.task_id] == ST_SUSPENDED)
            run_state[r.task_id] <= saved_state[r.task_id];
        end
        FN_KILL: begin
          if (tid_ok) run_state[r.task_id] <= ST_KILLED;
        end
        FN_PICK: begin
          if (rr_mode) begin
            last_valid <= have;
            if (have) last_picked <= best;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/task_state_scheduler_core.sv */
// Sequence: after the accepting edge, SCAN walks the task table in 16 record
//   scan steps, then 1 finish step in DONE raises out valid once out is free.
// Occupancy: one item is in work at a time; a new beat is taken only after
//   the result of the last one is posted.
// Reset: synchronous active-high rst; table returns to suspended records,
//   round_robin_mode to 0, no result pending.
// ----------------------------------------------------------------------------
// task_state_scheduler_core
// Task table scheduler: create, wait, signal, release, tick, suspend, resume, kill, pick over 16 records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module task_state_scheduler_core (
  input  wire logic  clk,
  input  wire logic  rst,
  tss_req_if.sink    in_ch,
  tss_rsp_if.source  out_ch,
  input  wire logic  psel,
  input  wire logic  penable,
  input  wire logic  pwrite,
  input  wire logic  [1:0] paddr,
  input  wire logic  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import tss_pkg::*;
  // the only register: selection mode, at byte address 0
  logic rr_mode;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, rr_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) rr_mode <= 1'b0;
    else if (psel && penable && pwrite && paddr == 2'd0) rr_mode <= pwdata[0];
  end

  // sequencer: IDLE takes a beat, SCAN walks all records, DONE posts result
  tss_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  // table and per-record update; result register feeds the output beat
  tss_dp u_dp (
    .clk(clk), .rst(rst), .rr_mode(rr_mode),
    .req(in_ch.data), .cmd(cmd), .sts(sts), .rsp(out_ch.data)
  );
endmodule
`default_nettype wire

/* sv/tss_checker.sv */
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "task_state_scheduler_core_assert.svh"
module tss_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic found,
  input wire logic [1:0] status
);
  import tss_pkg::*;
  `TSS_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `TSS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TSS_ASSERT_IMP(a_status_range, clk, rst, out_valid, status <= STS_DUP)
  `TSS_ASSERT_IMP(a_found_ok, clk, rst, out_valid && found, status == STS_OK)
endmodule

bind task_state_scheduler_core tss_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .found(out_ch.data.task_found), .status(out_ch.data.status)
);
`default_nettype wire
